// ===== src/sfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfpd_pkg
// Shared types and constants for the serial frame presence detector.
// ----------------------------------------------------------------------------
package sfpd_pkg;

  // frame layout
  localparam int unsigned FRAME_LEN  = 28;
  localparam int unsigned POS_W      = 5;
  localparam logic [POS_W-1:0] POS_HUNT    = 5'd0;
  localparam logic [POS_W-1:0] POS_MARK_A  = 5'd1;
  localparam logic [POS_W-1:0] POS_SUM_LO  = 5'd2;
  localparam logic [POS_W-1:0] POS_SUM_HI  = 5'd24;
  localparam logic [POS_W-1:0] POS_CHKSUM  = 5'd25;
  localparam logic [POS_W-1:0] POS_MARK_B  = 5'd26;
  localparam logic [POS_W-1:0] POS_LAST    = 5'(FRAME_LEN - 1);

  localparam logic [7:0] START_BYTE = 8'h55;
  localparam logic [7:0] MARK_FF    = 8'hFF;
  localparam logic [7:0] MARK_END   = 8'hFE;

  // counters
  localparam int unsigned COUNT_W = 10;
  localparam int unsigned TICK_W  = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TICK_W-1:0]  TICK_MAX  = '1;

  // configuration registers and their reset values
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_EARLY_WINDOW = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TOTAL_WINDOW = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_FRAMES   = 2'd2;

  localparam logic [TICK_W-1:0]  EARLY_WINDOW_RST = 16'd80;
  localparam logic [TICK_W-1:0]  TOTAL_WINDOW_RST = 16'd500;
  localparam logic [COUNT_W-1:0] MIN_FRAMES_RST   = 10'd12;

  // input commands
  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

endpackage

// ===== src/serial_frame_presence_detector_unit.sv =====
// ----------------------------------------------------------------------------
// serial_frame_presence_detector_unit
// Counts valid 28-byte serial frames inside a tick-based window and reports
// whether a device is present.
// ----------------------------------------------------------------------------
// output: the result of an accepted input transaction is registered at the
//   accepting edge into the output register
// throughput: one transaction per cycle unless the output stalls; the run state
//   updates in a single pass at the accepting edge; only stage: result register
// reset: synchronous rst clears the run state, loads the register defaults
//   (early 80, total 500, min 12) and empties the result register
module serial_frame_presence_detector_unit
  import sfpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,

  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,

  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]            s_axis_tuser,   // [1:0] cmd

  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // [9:0] frame_total, [10] run_done,
                                                // [11] device_found, [15:12] zero
  output logic                  m_axis_tuser    // [0] frame_good
);

  // configuration registers
  logic [TICK_W-1:0]  early_window_ms;
  logic [TICK_W-1:0]  total_window_ms;
  logic [COUNT_W-1:0] min_frames;

  // run state
  logic [POS_W-1:0]   frame_pos,     frame_pos_next;
  logic [7:0]         byte_sum,      byte_sum_next;
  logic               markers_ok,    markers_ok_next;
  logic [COUNT_W-1:0] good_count,    good_count_next;
  logic [TICK_W-1:0]  elapsed_ticks, elapsed_ticks_next;
  logic               window_closed, window_closed_next;
  logic               frame_good_next;

  // result register
  logic               frame_good;
  logic [COUNT_W-1:0] frame_total;
  logic               run_done;
  logic               device_found;

  logic in_xact;
  logic byte_ok;
  cmd_t cmd;

  // the result register frees up when its transaction is taken
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_xact       = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_t'(s_axis_tuser);

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      early_window_ms <= EARLY_WINDOW_RST;
      total_window_ms <= TOTAL_WINDOW_RST;
      min_frames      <= MIN_FRAMES_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_EARLY_WINDOW: early_window_ms <= cfg_data;
        REG_TOTAL_WINDOW: total_window_ms <= cfg_data;
        REG_MIN_FRAMES:   min_frames      <= cfg_data[COUNT_W-1:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // per-position byte check: markers and checksum
  always_comb begin
    if (frame_pos == POS_MARK_A || frame_pos == POS_MARK_B) begin
      byte_ok = (s_axis_tdata == MARK_FF);
    end else if (frame_pos == POS_CHKSUM) begin
      byte_ok = (s_axis_tdata == byte_sum);
    end else if (frame_pos == POS_LAST) begin
      byte_ok = (s_axis_tdata == MARK_END);
    end else begin
      byte_ok = 1'b1;  // payload bytes
    end
  end

  // next run state for the incoming transaction
  always_comb begin
    frame_pos_next     = frame_pos;
    byte_sum_next      = byte_sum;
    markers_ok_next    = markers_ok;
    good_count_next    = good_count;
    elapsed_ticks_next = elapsed_ticks;
    window_closed_next = window_closed;
    frame_good_next    = 1'b0;

    unique case (cmd)
      CMD_RESTART: begin
        frame_pos_next     = POS_HUNT;
        byte_sum_next      = '0;
        markers_ok_next    = 1'b1;
        good_count_next    = '0;
        elapsed_ticks_next = '0;
        window_closed_next = 1'b0;
      end
      CMD_BYTE: begin
        if (!window_closed) begin
          if (frame_pos == POS_HUNT) begin
            // hunting for the start byte
            if (s_axis_tdata == START_BYTE) begin
              frame_pos_next  = POS_MARK_A;
              byte_sum_next   = '0;
              markers_ok_next = 1'b1;
            end
          end else begin
            markers_ok_next = markers_ok && byte_ok;
            if (frame_pos >= POS_SUM_LO && frame_pos <= POS_SUM_HI) begin
              byte_sum_next = byte_sum + s_axis_tdata;
            end
            if (frame_pos >= POS_LAST) begin
              // frame complete, count it if every check passed
              frame_pos_next  = POS_HUNT;
              frame_good_next = markers_ok_next;
              if (markers_ok_next && good_count != COUNT_MAX) begin
                good_count_next = good_count + 1'b1;
              end
            end else begin
              frame_pos_next = frame_pos + 1'b1;
            end
          end
        end
      end
      CMD_TICK: begin
        if (!window_closed) begin
          if (elapsed_ticks != TICK_MAX) begin
            elapsed_ticks_next = elapsed_ticks + 1'b1;
          end
          // total window always closes; early window closes only with no frame yet
          if (elapsed_ticks_next >= total_window_ms) begin
            window_closed_next = 1'b1;
          end else if (elapsed_ticks_next > early_window_ms && good_count == '0) begin
            window_closed_next = 1'b1;
          end
        end
      end
      default: ;  // unused command leaves the state alone
    endcase
  end

  // run state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos     <= POS_HUNT;
      byte_sum      <= '0;
      markers_ok    <= 1'b1;
      good_count    <= '0;
      elapsed_ticks <= '0;
      window_closed <= 1'b0;
    end else if (in_xact) begin
      frame_pos     <= frame_pos_next;
      byte_sum      <= byte_sum_next;
      markers_ok    <= markers_ok_next;
      good_count    <= good_count_next;
      elapsed_ticks <= elapsed_ticks_next;
      window_closed <= window_closed_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_xact) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_xact) begin
      frame_good   <= frame_good_next;
      frame_total  <= good_count_next;
      run_done     <= window_closed_next;
      device_found <= window_closed_next && (good_count_next >= min_frames);
    end
  end

  assign m_axis_tuser = frame_good;
  assign m_axis_tdata = {4'b0000, device_found, run_done, frame_total};

endmodule
